// ===== design/vna_pkg.sv =====
// Shared types and constants of the vertex normal accumulator.
// Used by every module of the block; depends on nothing.
package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 64;
  localparam int ACCUM_WIDTH_DEF  = 48;

  localparam int IDX_W    = 6;   // vertex index field
  localparam int POS_W    = 16;  // Q8.8 position
  localparam int DIFF_W   = 17;  // corner difference
  localparam int FACE_W   = 35;  // cross product term, Q16.16
  localparam int UNIT_W   = 16;  // Q1.14 output
  localparam int FRAC_W   = 14;  // fraction bits of the output
  localparam int SCALE_W  = 30;  // scaled magnitudes lie below 2^SCALE_W
  localparam int SQ_W     = 62;  // sum of three squares
  localparam int RT_W     = 63;  // square root working registers
  localparam int LEN_W    = 31;  // vector length
  localparam int NUM_W    = 45;  // dividend of the unit value
  localparam int QUO_W    = 15;  // unit magnitude, up to 2^14

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic                     zero_normal;
  } out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [FACE_W-1:0] x;
    logic signed [FACE_W-1:0] y;
    logic signed [FACE_W-1:0] z;
  } face_t;

  // triangle command between control and the datapath units
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } tri_cmd_t;

  // status of the accumulator store
  typedef struct packed {
    logic init_busy;
    logic tri_done;
    logic rd_valid;
  } acc_stat_t;

endpackage

// ===== design/vna_geom.sv =====
// Position memory and face normal sequencer: reads three corners, forms
// (b-a)x(c-a) with one shared 17x17 multiplier. Depends on vna_pkg.
module vna_geom #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_we_i,
  input  logic [vna_pkg::IDX_W-1:0]  load_addr_i,
  input  vna_pkg::pos_t              load_pos_i,
  input  vna_pkg::tri_cmd_t          tri_i,
  output logic                       done_o,
  output vna_pkg::face_t             face_o
);
  import vna_pkg::*;

  localparam int ADDR_W = $clog2(VERTEX_COUNT);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RB   = 4'd1;
  localparam logic [3:0] ST_RC   = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_MUL0 = 4'd4;
  localparam logic [3:0] ST_ACC0 = 4'd5;
  localparam logic [3:0] ST_LAST = 4'd10;

  pos_t pos_mem [VERTEX_COUNT];
  pos_t rd_q, pa_q, pb_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0] b_q, c_q;
  logic [3:0] step_q;
  logic done_q;
  logic signed [DIFF_W-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [2*DIFF_W-1:0] prod_d, prod_q;
  logic [3:0] mk_full, ak_full;
  logic [2:0] mk, ak;
  face_t n_q;

  // read address follows the corner sequence
  always_comb begin
    case (step_q)
      ST_RB:   rd_addr = ADDR_W'(b_q);
      ST_RC:   rd_addr = ADDR_W'(c_q);
      default: rd_addr = ADDR_W'(tri_i.a);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_we_i) pos_mem[ADDR_W'(load_addr_i)] <= load_pos_i;
    rd_q <= pos_mem[rd_addr];
  end

  // operand select for the shared multiplier
  assign mk_full = step_q - ST_MUL0;
  assign ak_full = step_q - ST_ACC0;
  assign mk = mk_full[2:0];
  assign ak = ak_full[2:0];

  always_comb begin
    case (mk)
      3'd0:    begin op_a = uy_q; op_b = wz_q; end
      3'd1:    begin op_a = uz_q; op_b = wy_q; end
      3'd2:    begin op_a = uz_q; op_b = wx_q; end
      3'd3:    begin op_a = ux_q; op_b = wz_q; end
      3'd4:    begin op_a = ux_q; op_b = wy_q; end
      default: begin op_a = uy_q; op_b = wx_q; end
    endcase
  end
  assign prod_d = op_a * op_b;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (step_q == ST_IDLE && tri_i.start) begin
      b_q <= tri_i.b;
      c_q <= tri_i.c;
    end
    if (step_q == ST_RB) pa_q <= rd_q;
    if (step_q == ST_RC) pb_q <= rd_q;
    if (step_q == ST_DIFF) begin
      ux_q <= DIFF_W'(pb_q.x) - DIFF_W'(pa_q.x);
      uy_q <= DIFF_W'(pb_q.y) - DIFF_W'(pa_q.y);
      uz_q <= DIFF_W'(pb_q.z) - DIFF_W'(pa_q.z);
      wx_q <= DIFF_W'(rd_q.x) - DIFF_W'(pa_q.x);
      wy_q <= DIFF_W'(rd_q.y) - DIFF_W'(pa_q.y);
      wz_q <= DIFF_W'(rd_q.z) - DIFF_W'(pa_q.z);
      n_q  <= '0;
    end
    if (step_q >= ST_MUL0) prod_q <= prod_d;
    if (step_q >= ST_ACC0) begin
      case (ak)
        3'd0:    n_q.x <= n_q.x + FACE_W'(prod_q);
        3'd1:    n_q.x <= n_q.x - FACE_W'(prod_q);
        3'd2:    n_q.y <= n_q.y + FACE_W'(prod_q);
        3'd3:    n_q.y <= n_q.y - FACE_W'(prod_q);
        3'd4:    n_q.z <= n_q.z + FACE_W'(prod_q);
        default: n_q.z <= n_q.z - FACE_W'(prod_q);
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == ST_LAST);
      if (step_q == ST_IDLE) begin
        if (tri_i.start) step_q <= ST_RB;
      end else if (step_q == ST_LAST) begin
        step_q <= ST_IDLE;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  assign done_o = done_q;
  assign face_o = n_q;

endmodule

// ===== design/vna_acc.sv =====
// Accumulator memory with clearing pass, load clear, saturating
// read-modify-write of three corners and a read port. Depends on vna_pkg.
module vna_acc #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
  parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_we_i,
  input  logic [vna_pkg::IDX_W-1:0]     load_addr_i,
  input  vna_pkg::tri_cmd_t             tri_i,
  input  vna_pkg::face_t                face_i,
  input  logic                          rd_start_i,
  input  logic [vna_pkg::IDX_W-1:0]     rd_addr_i,
  output vna_pkg::acc_stat_t            stat_o,
  output logic signed [ACCUM_WIDTH-1:0] rd_x_o,
  output logic signed [ACCUM_WIDTH-1:0] rd_y_o,
  output logic signed [ACCUM_WIDTH-1:0] rd_z_o
);
  import vna_pkg::*;

  localparam int ADDR_W  = $clog2(VERTEX_COUNT);
  localparam int ENTRY_W = 3 * ACCUM_WIDTH;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_WA   = 3'd1;
  localparam logic [2:0] P_RB   = 3'd2;
  localparam logic [2:0] P_WB   = 3'd3;
  localparam logic [2:0] P_RC   = 3'd4;
  localparam logic [2:0] P_WC   = 3'd5;

  logic [ENTRY_W-1:0] acc_mem [VERTEX_COUNT];
  logic [ENTRY_W-1:0] mem_q, wdata;
  logic [ADDR_W-1:0] raddr, waddr, clr_cnt_q;
  logic we, clearing_q, rd_pend_q, tri_done_q;
  logic [2:0] phase_q;
  logic [IDX_W-1:0] a_q, b_q, c_q, wcorner;
  logic signed [ACCUM_WIDTH-1:0] cur_x, cur_y, cur_z;

  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] a,
    input logic signed [FACE_W-1:0]      b
  );
    logic signed [ACCUM_WIDTH:0] s;
    s = (ACCUM_WIDTH+1)'(a) + (ACCUM_WIDTH+1)'(b);
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      sat_add = s[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end else begin
      sat_add = s[ACCUM_WIDTH-1:0];
    end
  endfunction

  assign cur_x = mem_q[ENTRY_W-1 -: ACCUM_WIDTH];
  assign cur_y = mem_q[2*ACCUM_WIDTH-1 -: ACCUM_WIDTH];
  assign cur_z = mem_q[ACCUM_WIDTH-1:0];

  // read address: corner sequence, then read request, then first corner
  always_comb begin
    case (phase_q)
      P_RB:    raddr = ADDR_W'(b_q);
      P_RC:    raddr = ADDR_W'(c_q);
      default: raddr = rd_start_i ? ADDR_W'(rd_addr_i) : ADDR_W'(tri_i.a);
    endcase
  end

  always_comb begin
    case (phase_q)
      P_WA:    wcorner = a_q;
      P_WB:    wcorner = b_q;
      default: wcorner = c_q;
    endcase
  end

  // write port: clearing pass, load clear, corner update
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(wcorner);
    wdata = {sat_add(cur_x, face_i.x), sat_add(cur_y, face_i.y),
             sat_add(cur_z, face_i.z)};
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (load_we_i) begin
      we    = 1'b1;
      waddr = ADDR_W'(load_addr_i);
      wdata = '0;
    end else if (phase_q == P_WA || phase_q == P_WB || phase_q == P_WC) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) acc_mem[waddr] <= wdata;
    mem_q <= acc_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == P_IDLE && tri_i.start) begin
      a_q <= tri_i.a;
      b_q <= tri_i.b;
      c_q <= tri_i.c;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      phase_q    <= P_IDLE;
      rd_pend_q  <= 1'b0;
      tri_done_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(VERTEX_COUNT - 1)) clearing_q <= 1'b0;
      end
      rd_pend_q  <= rd_start_i;
      tri_done_q <= (phase_q == P_WC);
      if (phase_q == P_IDLE) begin
        if (tri_i.start) phase_q <= P_WA;
      end else if (phase_q == P_WC) begin
        phase_q <= P_IDLE;
      end else begin
        phase_q <= phase_q + 3'd1;
      end
    end
  end

  assign stat_o.init_busy = clearing_q;
  assign stat_o.tri_done  = tri_done_q;
  assign stat_o.rd_valid  = rd_pend_q;
  assign rd_x_o = cur_x;
  assign rd_y_o = cur_y;
  assign rd_z_o = cur_z;

endmodule

// ===== design/vna_norm.sv =====
// Normalization unit: common scaling shift, squares, bitwise square
// root and three restoring dividers in lanes. Depends on vna_pkg.
module vna_norm #(
  parameter int ACCUM_WIDTH = vna_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ACCUM_WIDTH-1:0] acc_x_i,
  input  logic signed [ACCUM_WIDTH-1:0] acc_y_i,
  input  logic signed [ACCUM_WIDTH-1:0] acc_z_i,
  output logic                          done_o,
  output vna_pkg::out_t                 res_o
);
  import vna_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SCALE = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_PREP  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_FIN   = 3'd6;

  logic [2:0] phase_q;
  logic [3:0] cnt_q;
  logic done_q;
  out_t res_q;

  logic [ACCUM_WIDTH-1:0] acc_in [3];
  logic [ACCUM_WIDTH-1:0] mag_in [3];
  logic [ACCUM_WIDTH-1:0] m_q [3];
  logic neg_q [3];
  logic [ACCUM_WIDTH-1:0] or_in, or_m;

  logic [SCALE_W-1:0] msel;
  logic [2*SCALE_W-1:0] prod_q;
  logic [SQ_W-1:0] sum_q, v_q;
  logic [RT_W-1:0] root_q, bit_q;
  logic [RT_W:0] trial;
  logic root_ge;
  logic [LEN_W-1:0] len;
  logic [NUM_W-1:0] d_q;
  logic [NUM_W-1:0] rem_q [3];
  logic [QUO_W-1:0] q_q [3];
  logic [UNIT_W-1:0] uq [3];
  logic [UNIT_W-1:0] us [3];

  assign acc_in[0] = acc_x_i;
  assign acc_in[1] = acc_y_i;
  assign acc_in[2] = acc_z_i;

  // magnitudes of the incoming accumulator and of the held ones
  always_comb begin
    or_in = '0;
    or_m  = '0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = acc_in[i][ACCUM_WIDTH-1] ? (~acc_in[i] + 1'b1) : acc_in[i];
      or_in     = or_in | mag_in[i];
      or_m      = or_m | m_q[i];
    end
  end

  assign msel = (cnt_q == 4'd0) ? m_q[0][SCALE_W-1:0] :
                (cnt_q == 4'd1) ? m_q[1][SCALE_W-1:0] : m_q[2][SCALE_W-1:0];

  assign trial   = {1'b0, root_q} + {1'b0, bit_q};
  assign root_ge = (RT_W+1)'(v_q) >= trial;
  assign len     = root_q[LEN_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq[i] = {1'b0, q_q[i]};
      us[i] = neg_q[i] ? (~uq[i] + 1'b1) : uq[i];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (phase_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= mag_in[i];
            neg_q[i] <= acc_in[i][ACCUM_WIDTH-1];
          end
          if (or_in == '0) res_q <= '{unit_x: '0, unit_y: '0, unit_z: '0,
                                      zero_normal: 1'b1};
          sum_q <= '0;
        end
      end
      N_SCALE: begin
        // largest magnitude brought into [2^29, 2^30)
        for (int i = 0; i < 3; i++) begin
          if (|or_m[ACCUM_WIDTH-1:SCALE_W+4])    m_q[i] <= m_q[i] >> 4;
          else if (|or_m[ACCUM_WIDTH-1:SCALE_W]) m_q[i] <= m_q[i] >> 1;
          else if (!or_m[SCALE_W-1]) begin
            if (or_m[SCALE_W-1 -: 4] == 4'd0) m_q[i] <= m_q[i] << 4;
            else                              m_q[i] <= m_q[i] << 1;
          end
        end
      end
      N_SQ: begin
        prod_q <= msel * msel;
        if (cnt_q != 4'd0) sum_q <= sum_q + SQ_W'(prod_q);
        if (cnt_q == 4'd3) begin
          v_q    <= sum_q + SQ_W'(prod_q);
          root_q <= '0;
          bit_q  <= RT_W'(1) << SQ_W;
        end
      end
      N_ROOT: begin
        if (root_ge) begin
          v_q    <= v_q - SQ_W'(trial);
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_PREP: begin
        d_q <= {len, {FRAC_W{1'b0}}};
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= NUM_W'({m_q[i][SCALE_W-1:0], {FRAC_W{1'b0}}}) +
                      NUM_W'(len >> 1);
          q_q[i]   <= '0;
        end
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= d_q) begin
            rem_q[i] <= rem_q[i] - d_q;
            q_q[i]   <= {q_q[i][QUO_W-2:0], 1'b1};
          end else begin
            q_q[i]   <= {q_q[i][QUO_W-2:0], 1'b0};
          end
        end
        d_q <= d_q >> 1;
      end
      N_FIN: begin
        res_q <= '{unit_x: us[0], unit_y: us[1], unit_z: us[2],
                   zero_normal: 1'b0};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= N_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      // done after the last step, or at once for a zero-length normal
      done_q <= (phase_q == N_FIN) ||
                ((phase_q == N_IDLE) && start_i && (or_in == '0));
      case (phase_q)
        N_IDLE: begin
          if (start_i && (or_in != '0)) phase_q <= N_SCALE;
        end
        N_SCALE: begin
          if (!(|or_m[ACCUM_WIDTH-1:SCALE_W]) && or_m[SCALE_W-1]) begin
            phase_q <= N_SQ;
            cnt_q   <= '0;
          end
        end
        N_SQ: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd3) phase_q <= N_ROOT;
        end
        N_ROOT: if (bit_q[0]) phase_q <= N_PREP;
        N_PREP: begin
          phase_q <= N_DIV;
          cnt_q   <= '0;
        end
        N_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(QUO_W - 1)) phase_q <= N_FIN;
        end
        N_FIN: phase_q <= N_IDLE;
        default: phase_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/vertex_normal_accumulator_top.sv =====
// Top level of the vertex normal accumulator: control sequencer and
// output register. Depends on vna_pkg, vna_geom, vna_acc and vna_norm.
//
//  channel | signals                          | payload
//  --------+----------------------------------+-------------------
//  input   | in_valid_i / in_ready_o          | in_data_i  (in_t)
//  output  | out_valid_o / out_ready_i        | out_data_o (out_t)
//
// One item at a time. A load is written as it is taken; a triangle runs three
// position reads, six passes through the shared multiplier and three
// accumulator read-modify-writes on the single accumulator write port. A read
// runs through the 32-step square root and the 15-step dividers; a zero-length
// normal skips them. After reset the accumulator memory is cleared, one entry
// a cycle, through all VERTEX_COUNT entries; no input is taken meanwhile.
// A stalled output holds one result while the next item is taken.
module vertex_normal_accumulator_top #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
  parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vna_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vna_pkg::out_t out_data_o
);
  import vna_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GEOM   = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_NORM   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q;
  logic accept, vi_ok, corners_ok, out_free;
  logic load_we, rd_start, geom_done, norm_done, out_valid_q;
  tri_cmd_t geom_cmd, acc_cmd;
  logic [IDX_W-1:0] ca_q, cb_q, cc_q;
  pos_t load_pos;
  face_t face;
  acc_stat_t acc_stat;
  logic signed [ACCUM_WIDTH-1:0] rd_x, rd_y, rd_z;
  out_t norm_res, pend_q, out_q;

  assign in_ready_o = (state_q == S_IDLE) && !acc_stat.init_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign vi_ok      = int'(in_data_i.vertex_index) < VERTEX_COUNT;
  assign corners_ok = (int'(in_data_i.corner_a) < VERTEX_COUNT) &&
                      (int'(in_data_i.corner_b) < VERTEX_COUNT) &&
                      (int'(in_data_i.corner_c) < VERTEX_COUNT);

  assign load_we  = accept && (in_data_i.operation == OP_LOAD) && vi_ok;
  assign rd_start = accept && (in_data_i.operation == OP_READ) && vi_ok;
  assign load_pos = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};

  assign geom_cmd = '{start: accept && (in_data_i.operation == OP_TRI) && corners_ok,
                      a: in_data_i.corner_a, b: in_data_i.corner_b,
                      c: in_data_i.corner_c};
  assign acc_cmd  = '{start: (state_q == S_GEOM) && geom_done,
                      a: ca_q, b: cb_q, c: cc_q};

  vna_geom #(.VERTEX_COUNT(VERTEX_COUNT)) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_we_i   (load_we),
    .load_addr_i (in_data_i.vertex_index),
    .load_pos_i  (load_pos),
    .tri_i       (geom_cmd),
    .done_o      (geom_done),
    .face_o      (face)
  );

  vna_acc #(.VERTEX_COUNT(VERTEX_COUNT), .ACCUM_WIDTH(ACCUM_WIDTH)) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_we_i   (load_we),
    .load_addr_i (in_data_i.vertex_index),
    .tri_i       (acc_cmd),
    .face_i      (face),
    .rd_start_i  (rd_start),
    .rd_addr_i   (in_data_i.vertex_index),
    .stat_o      (acc_stat),
    .rd_x_o      (rd_x),
    .rd_y_o      (rd_y),
    .rd_z_o      (rd_z)
  );

  vna_norm #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_RDWAIT) && acc_stat.rd_valid),
    .acc_x_i (rd_x),
    .acc_y_i (rd_y),
    .acc_z_i (rd_z),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // corner latch and pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ca_q <= in_data_i.corner_a;
      cb_q <= in_data_i.corner_b;
      cc_q <= in_data_i.corner_c;
    end
    if (accept && in_data_i.operation == OP_READ && !vi_ok)
      pend_q <= '{unit_x: '0, unit_y: '0, unit_z: '0, zero_normal: 1'b1};
    else if (state_q == S_NORM && norm_done)
      pend_q <= norm_res;
    if (state_q == S_OUT && out_free) out_q <= pend_q;
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // set when a result moves to the output, cleared on its transfer
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (geom_cmd.start) state_q <= S_GEOM;
            else if (rd_start) state_q <= S_RDWAIT;
            else if (in_data_i.operation == OP_READ) state_q <= S_OUT;
          end
        end
        S_GEOM:   if (geom_done) state_q <= S_ACC;
        S_ACC:    if (acc_stat.tri_done) state_q <= S_IDLE;
        S_RDWAIT: if (acc_stat.rd_valid) state_q <= S_NORM;
        S_NORM:   if (norm_done) state_q <= S_OUT;
        S_OUT:    if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/vna_checker.sv =====
// Port-level checks of the vertex normal accumulator, bound to the top.
// Depends on vna_pkg and vertex_normal_accumulator_top.
module vna_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input vna_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input vna_pkg::out_t out_data_o
);
  import vna_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a read transfer keeps the input closed next cycle
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation == OP_READ |=> !in_ready_o)
    else $error("input open right after a read");

  // a triangle transfer keeps the input closed next cycle
  a_tri_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation == OP_TRI |=> !in_ready_o)
    else $error("input open right after a triangle");

  // zero-length flag comes with zero unit fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_normal |->
      out_data_o.unit_x == 0 && out_data_o.unit_y == 0 && out_data_o.unit_z == 0)
    else $error("zero normal with nonzero fields");

  // unit values stay within one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.unit_x >= -16384 && out_data_o.unit_x <= 16384 &&
      out_data_o.unit_y >= -16384 && out_data_o.unit_y <= 16384 &&
      out_data_o.unit_z >= -16384 && out_data_o.unit_z <= 16384)
    else $error("unit value out of range");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);

// ===== dv/vertex_normal_accumulator_top_tb.sv =====
// Testbench of the vertex normal accumulator: directed table, then random traffic.
// Depends on vna_pkg and vertex_normal_accumulator_top; self-checking against its own model.
module vertex_normal_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int NVERT = 64;
  localparam int ACCW  = 48;
  localparam int NRAND = 1850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  vertex_normal_accumulator_top dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic signed [15:0]     pos_x_m [NVERT];
  logic signed [15:0]     pos_y_m [NVERT];
  logic signed [15:0]     pos_z_m [NVERT];
  logic signed [ACCW-1:0] acc_x_m [NVERT];
  logic signed [ACCW-1:0] acc_y_m [NVERT];
  logic signed [ACCW-1:0] acc_z_m [NVERT];
  bit                     loaded [NVERT];

  out_t normals_due[$];
  int   fail_cnt = 0;
  int   reads_seen = 0;
  int   tris_sent = 0;
  int   send_idle = 0;
  int   recv_stall = 0;

  function automatic logic signed [ACCW-1:0] sat_sum(logic signed [ACCW-1:0] a,
                                                     longint b);
    longint hi, lo, s;
    hi = (longint'(1) <<< (ACCW-1)) - 1;
    lo = -hi - 1;
    s = longint'(a) + b;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[ACCW-1:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_of(longint unsigned m, longint unsigned len,
                                          bit neg);
    longint unsigned q;
    q = (m * 16384 + len / 2) / len;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  // Advance the model by one transfer; returns 1 when a result is due.
  function automatic bit predict_normal(in_t it, output out_t r);
    longint ux, uy, uz, wx, wy, wz, nx, ny, nz, cx, cy, cz;
    longint unsigned mx, my, mz, big, len;
    int n, k;
    int cs[3];
    r = '0;
    case (it.operation)
      OP_LOAD: begin
        pos_x_m[it.vertex_index] = it.pos_x;
        pos_y_m[it.vertex_index] = it.pos_y;
        pos_z_m[it.vertex_index] = it.pos_z;
        acc_x_m[it.vertex_index] = '0;
        acc_y_m[it.vertex_index] = '0;
        acc_z_m[it.vertex_index] = '0;
        loaded[it.vertex_index] = 1'b1;
        return 1'b0;
      end
      OP_TRI: begin
        ux = longint'(pos_x_m[it.corner_b]) - pos_x_m[it.corner_a];
        uy = longint'(pos_y_m[it.corner_b]) - pos_y_m[it.corner_a];
        uz = longint'(pos_z_m[it.corner_b]) - pos_z_m[it.corner_a];
        wx = longint'(pos_x_m[it.corner_c]) - pos_x_m[it.corner_a];
        wy = longint'(pos_y_m[it.corner_c]) - pos_y_m[it.corner_a];
        wz = longint'(pos_z_m[it.corner_c]) - pos_z_m[it.corner_a];
        nx = uy * wz - uz * wy;
        ny = uz * wx - ux * wz;
        nz = ux * wy - uy * wx;
        cs[0] = it.corner_a; cs[1] = it.corner_b; cs[2] = it.corner_c;
        foreach (cs[i]) begin
          acc_x_m[cs[i]] = sat_sum(acc_x_m[cs[i]], nx);
          acc_y_m[cs[i]] = sat_sum(acc_y_m[cs[i]], ny);
          acc_z_m[cs[i]] = sat_sum(acc_z_m[cs[i]], nz);
        end
        return 1'b0;
      end
      OP_READ: begin
        cx = acc_x_m[it.vertex_index];
        cy = acc_y_m[it.vertex_index];
        cz = acc_z_m[it.vertex_index];
        mx = cx < 0 ? -cx : cx;
        my = cy < 0 ? -cy : cy;
        mz = cz < 0 ? -cz : cz;
        big = mx;
        if (my > big) big = my;
        if (mz > big) big = mz;
        if (big == 0) begin
          r.zero_normal = 1'b1;
          return 1'b1;
        end
        n = 0;
        for (k = 0; k < 64; k++) if (big >> k) n = k + 1;
        if (n > 30) begin
          mx >>= (n - 30); my >>= (n - 30); mz >>= (n - 30);
        end else if (n < 30) begin
          mx <<= (30 - n); my <<= (30 - n); mz <<= (30 - n);
        end
        len = root_floor(mx * mx + my * my + mz * mz);
        r.unit_x = unit_of(mx, len, cx < 0);
        r.unit_y = unit_of(my, len, cy < 0);
        r.unit_z = unit_of(mz, len, cz < 0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one item until its transfer, honoring the sender idle ratio.
  task automatic drive_item(in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hand one item over and advance the model.
  task automatic send_item(in_t it);
    out_t r;
    drive_item(it);
    if (predict_normal(it, r)) normals_due.push_back(r);
    if (it.operation == OP_TRI) tris_sent++;
  endtask

  // Receiver: random stalls, checks every transfer in order.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
    if (rst_ni && out_valid_o && out_ready_i) begin
      reads_seen++;
      if (normals_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected normal %p", out_data_o);
      end else begin
        out_t e;
        e = normals_due.pop_front();
        if (e.unit_x !== out_data_o.unit_x || e.unit_y !== out_data_o.unit_y ||
            e.unit_z !== out_data_o.unit_z || e.zero_normal !== out_data_o.zero_normal) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("normal mismatch: exp %p got %p", e, out_data_o);
        end
      end
    end
  end

  function automatic in_t mk(logic [1:0] op, int v, int px, int py, int pz,
                             int a, int b, int c);
    in_t it;
    it.operation = op; it.vertex_index = v[5:0];
    it.pos_x = px[15:0]; it.pos_y = py[15:0]; it.pos_z = pz[15:0];
    it.corner_a = a[5:0]; it.corner_b = b[5:0]; it.corner_c = c[5:0];
    return it;
  endfunction

  function automatic int rand_vertex();
    int v;
    do v = $urandom_range(NVERT - 1); while (!loaded[v]);
    return v;
  endfunction

  function automatic in_t rand_item(bit extreme);
    in_t it;
    int pick, sel;
    it = in_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 25) it.operation = OP_LOAD;
    else if (pick < 70) it.operation = OP_TRI;
    else if (pick < 97) it.operation = OP_READ;
    else it.operation = 2'd3;
    if (it.operation == OP_LOAD) begin
      sel = $urandom_range(3);
      if (!extreme && sel != 0) begin
        it.pos_x = 16'($signed($urandom_range(4095)) - 2048);
        it.pos_y = 16'($signed($urandom_range(4095)) - 2048);
        it.pos_z = 16'($signed($urandom_range(4095)) - 2048);
      end
    end
    it.corner_a = rand_vertex();
    it.corner_b = rand_vertex();
    it.corner_c = rand_vertex();
    if ($urandom_range(9) == 0) it.corner_c = it.corner_a;
    if (it.operation == OP_READ && $urandom_range(1)) it.vertex_index = rand_vertex();
    return it;
  endfunction

  in_t plan[$];
  bit   fixed_has[$];

  initial begin
    in_t it;
    out_t r;
    foreach (loaded[i]) loaded[i] = 1'b0;
    foreach (acc_x_m[i]) begin
      acc_x_m[i] = '0; acc_y_m[i] = '0; acc_z_m[i] = '0;
      pos_x_m[i] = '0; pos_y_m[i] = '0; pos_z_m[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, all operations, repeated corners, zero normals
    plan = '{
      mk(OP_READ, 5, 0, 0, 0, 0, 0, 0),
      mk(OP_READ, 63, 0, 0, 0, 0, 0, 0),
      mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_LOAD, 1, 256, 0, 0, 0, 0, 0),
      mk(OP_LOAD, 2, 0, 256, 0, 0, 0, 0),
      mk(OP_TRI, 0, 0, 0, 0, 0, 1, 2),
      mk(OP_READ, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_LOAD, 3, -32768, -32768, -32768, 0, 0, 0),
      mk(OP_LOAD, 4, 32767, -32768, 32767, 0, 0, 0),
      mk(OP_LOAD, 63, -32768, 32767, 32767, 0, 0, 0),
      mk(OP_TRI, 0, 0, 0, 0, 3, 4, 63),
      mk(OP_TRI, 0, 0, 0, 0, 3, 4, 63),
      mk(OP_TRI, 0, 0, 0, 0, 3, 63, 4),
      mk(OP_READ, 3, 0, 0, 0, 0, 0, 0),
      mk(OP_READ, 63, 0, 0, 0, 0, 0, 0),
      mk(OP_TRI, 0, 0, 0, 0, 1, 1, 2),
      mk(OP_READ, 1, 0, 0, 0, 0, 0, 0),
      mk(2'd3, 0, -1, -1, -1, 63, 63, 63),
      mk(OP_LOAD, 3, 5, 5, 5, 0, 0, 0),
      mk(OP_READ, 3, 0, 0, 0, 0, 0, 0)
    };
    // rows readable at a glance: zero normals and the unit z from the first triangle
    foreach (plan[i]) fixed_has.push_back(1'b0);
    fixed_has[0] = 1; fixed_has[1] = 1; fixed_has[6] = 1; fixed_has[19] = 1;
    foreach (plan[i]) begin
      if (fixed_has[i]) begin
        void'(predict_normal(plan[i], r));
        if (i == 6) r = '{unit_x: '0, unit_y: '0, unit_z: 16'sd16384, zero_normal: 1'b0};
        else r = '{unit_x: '0, unit_y: '0, unit_z: '0, zero_normal: 1'b1};
        normals_due.push_back(r);
        drive_item(plan[i]);
      end else begin
        send_item(plan[i]);
      end
    end

    // make every vertex valid before random triangles
    for (int v = 0; v < NVERT; v++)
      if (!loaded[v]) send_item(mk(OP_LOAD, v, $urandom, $urandom, $urandom, 0, 0, 0));

    // random phases over four idle patterns; the last phase uses unrestricted positions
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        3: begin send_idle = 16; recv_stall = 16; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int k = 0; k < NRAND / 5; k++) begin
        it = rand_item(ph == 4);
        send_item(it);
      end
    end
    in_valid_i <= 1'b0;

    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d triangles and %0d normal reads under four idle patterns",
             tris_sent, reads_seen);
    if (fail_cnt == 0) $display("** vertex_normal_accumulator_top: PASSED **");
    else $display("** vertex_normal_accumulator_top: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("** vertex_normal_accumulator_top: FAILED **");
    $finish;
  end
endmodule
